>>> sv/osk_pkg.sv
// osk_pkg: shared types and constants for the omni base slew kinematics block.
// Holds the configuration register map, reset values and fixed field widths.
// No dependencies.
package osk_pkg;

    localparam int VEL_BITS_DEF = 16;
    localparam int CMD_W        = 16;
    localparam int TGT_W        = 16;
    localparam int CFG_W        = 15;
    localparam int CFG_IDX_W    = 3;
    localparam int ROUND_SHIFT  = 14;
    localparam int MID_DEPTH    = 2;
    localparam int OUT_DEPTH    = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LIMIT_ENABLE = 3'd0,
        CFG_MAX_STEP_X   = 3'd1,
        CFG_MAX_STEP_Y   = 3'd2,
        CFG_MAX_STEP_W   = 3'd3,
        CFG_AXIS_GAIN    = 3'd4,
        CFG_BASE_RADIUS  = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic             limit_enable;
        logic [CFG_W-1:0] max_step_x;
        logic [CFG_W-1:0] max_step_y;
        logic [CFG_W-1:0] max_step_w;
        logic [CFG_W-1:0] axis_gain;
        logic [CFG_W-1:0] base_radius;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        limit_enable: 1'b1,
        max_step_x:   15'd328,
        max_step_y:   15'd328,
        max_step_w:   15'd328,
        axis_gain:    15'd11585,
        base_radius:  15'd1638
    };

endpackage

>>> sv/osk_fifo.sv
// osk_fifo: small register-based queue with first-word fall-through read.
// Used between front and back and as the result queue.
// Depends on nothing.
module osk_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         wr_en,
    input  logic [WIDTH-1:0]             wr_data,
    input  logic                         rd_en,
    output logic [WIDTH-1:0]             rd_data,
    output logic                         full,
    output logic                         empty,
    output logic [$clog2(DEPTH+1)-1:0]   count
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign count   = count_reg;
    assign rd_data = mem_reg[rd_ptr_reg];
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

>>> sv/osk_front.sv
// osk_front: slew limiter on the commanded body velocity, holds last applied values.
// Produces the applied (vx, vy, w) for each transfer.
// Depends on osk_pkg.
module osk_front #(
    parameter int VEL_BITS = osk_pkg::VEL_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                accept,
    input  logic signed [osk_pkg::CMD_W-1:0]    vx_cmd,
    input  logic signed [osk_pkg::CMD_W-1:0]    vy_cmd,
    input  logic signed [osk_pkg::CMD_W-1:0]    w_cmd,
    input  osk_pkg::cfg_t                       cfg,
    output logic [3*VEL_BITS-1:0]               applied
);

    localparam int DW = ((VEL_BITS > osk_pkg::CMD_W) ? VEL_BITS : osk_pkg::CMD_W) + 2;
    localparam logic signed [DW-1:0] VEL_MAX =
        {{(DW - VEL_BITS + 1){1'b0}}, {(VEL_BITS - 1){1'b1}}};
    localparam logic signed [DW-1:0] VEL_MIN = ~VEL_MAX;

    logic signed [VEL_BITS-1:0] last_vx_reg, last_vx_next;
    logic signed [VEL_BITS-1:0] last_vy_reg, last_vy_next;
    logic signed [VEL_BITS-1:0] last_w_reg, last_w_next;

    function automatic logic signed [VEL_BITS-1:0] slew(
        input logic [osk_pkg::CMD_W-1:0] cmd,
        input logic [VEL_BITS-1:0]       last,
        input logic [osk_pkg::CFG_W-1:0] step,
        input logic                      en
    );
        logic signed [DW-1:0] c, l, s, d, r;
        c = {{(DW - osk_pkg::CMD_W){cmd[osk_pkg::CMD_W-1]}}, cmd};
        l = {{(DW - VEL_BITS){last[VEL_BITS-1]}}, last};
        s = {{(DW - osk_pkg::CFG_W){1'b0}}, step};
        d = c - l;
        r = c;
        if (en)
        begin
            if (d > s)
            begin
                r = l + s;
            end
            else if (d < -s)
            begin
                r = l - s;
            end
        end
        if (r > VEL_MAX)
        begin
            r = VEL_MAX;
        end
        else if (r < VEL_MIN)
        begin
            r = VEL_MIN;
        end
        return r[VEL_BITS-1:0];
    endfunction

    always_comb
    begin
        last_vx_next = slew(vx_cmd, last_vx_reg, cfg.max_step_x, cfg.limit_enable);
        last_vy_next = slew(vy_cmd, last_vy_reg, cfg.max_step_y, cfg.limit_enable);
        last_w_next  = slew(w_cmd, last_w_reg, cfg.max_step_w, cfg.limit_enable);
    end

    assign applied = {last_vx_next, last_vy_next, last_w_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_vx_reg <= '0;
            last_vy_reg <= '0;
            last_w_reg  <= '0;
        end
        else if (accept)
        begin
            last_vx_reg <= last_vx_next;
            last_vy_reg <= last_vy_next;
            last_w_reg  <= last_w_next;
        end
    end

endmodule

>>> sv/osk_back.sv
// osk_back: wheel kinematics (multiply stage, then sum, round, saturate) and result queue.
// Pulls applied velocities from the middle queue when the result queue has room.
// Depends on osk_pkg and osk_fifo.
module osk_back #(
    parameter int VEL_BITS  = osk_pkg::VEL_BITS_DEF,
    parameter int OUT_DEPTH = osk_pkg::OUT_DEPTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_empty,
    input  logic [3*VEL_BITS-1:0]               in_data,
    output logic                                in_pop,
    input  osk_pkg::cfg_t                       cfg,
    input  logic                                pop,
    output logic                                empty,
    output logic signed [osk_pkg::TGT_W-1:0]    front_left_target,
    output logic signed [osk_pkg::TGT_W-1:0]    front_right_target,
    output logic signed [osk_pkg::TGT_W-1:0]    back_right_target,
    output logic signed [osk_pkg::TGT_W-1:0]    back_left_target
);

    localparam int PW  = VEL_BITS + osk_pkg::CFG_W + 1;
    localparam int SW  = ((VEL_BITS + 20) > 32) ? (VEL_BITS + 20) : 32;
    localparam int CW  = $clog2(OUT_DEPTH + 1);
    localparam int TW  = osk_pkg::TGT_W;
    localparam logic signed [SW-1:0] RND   = SW'(1) <<< (osk_pkg::ROUND_SHIFT - 1);
    localparam logic signed [SW-1:0] T_MAX = SW'((1 << (TW - 1)) - 1);
    localparam logic signed [SW-1:0] T_MIN = ~T_MAX;

    logic signed [VEL_BITS-1:0] vx, vy, w;
    logic signed [PW-1:0]       gx_next, gy_next, wr_prod;
    logic signed [PW-1:0]       gx_reg, gy_reg;
    logic signed [PW+1:0]       wr_reg, wr_next;
    logic                       s1_valid_reg;
    logic signed [SW-1:0]       gx_e, gy_e, wr_e;
    logic [4*TW-1:0]            res_data, out_data;
    logic                       out_full;
    logic [CW-1:0]              out_count;
    logic                       room;

    function automatic logic signed [TW-1:0] finish(input logic signed [SW-1:0] q);
        logic signed [SW-1:0] t;
        t = (q + RND) >>> osk_pkg::ROUND_SHIFT;
        if (t > T_MAX)
        begin
            t = T_MAX;
        end
        else if (t < T_MIN)
        begin
            t = T_MIN;
        end
        return t[TW-1:0];
    endfunction

    assign {vx, vy, w} = in_data;

    assign room   = ((CW + 1)'(out_count) + (CW + 1)'(s1_valid_reg)) < (CW + 1)'(OUT_DEPTH);
    assign in_pop = !in_empty && room;

    always_comb
    begin
        gx_next = vx * $signed({1'b0, cfg.axis_gain});
        gy_next = vy * $signed({1'b0, cfg.axis_gain});
        wr_prod = w * $signed({1'b0, cfg.base_radius});
        wr_next = {wr_prod, 2'b00};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_pop;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_pop)
        begin
            gx_reg <= gx_next;
            gy_reg <= gy_next;
            wr_reg <= wr_next;
        end
    end

    always_comb
    begin
        gx_e = SW'(gx_reg);
        gy_e = SW'(gy_reg);
        wr_e = SW'(wr_reg);
        res_data = {finish(gy_e + gx_e - wr_e),
                    finish(gx_e - gy_e - wr_e),
                    finish(-gy_e - gx_e - wr_e),
                    finish(gy_e - gx_e - wr_e)};
    end

    osk_fifo #(
        .WIDTH (4 * TW),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (s1_valid_reg),
        .wr_data (res_data),
        .rd_en   (pop),
        .rd_data (out_data),
        .full    (out_full),
        .empty   (empty),
        .count   (out_count)
    );

    assign {front_left_target, front_right_target, back_right_target, back_left_target} =
        out_full ? out_data : out_data;

endmodule

>>> sv/omni_base_slew_kinematics.sv
// omni_base_slew_kinematics: top level, configuration registers and queue wiring.
// Depends on osk_pkg, osk_fifo, osk_front, osk_back.
//
// Usage:
//   Commands enter through a queue-like port: a transfer happens at a clock
//   edge with push high and full low. Each command (vx_cmd, vy_cmd, w_cmd)
//   yields one result of four wheel targets, read through empty/pop: the
//   oldest result is on the target ports while empty is low and is removed
//   at an edge with pop high.
//   Configuration: cfg_wr_en with cfg_addr/cfg_wdata writes one register in
//   the same edge; unknown indexes are ignored. Write only while idle.
//   Path: the slew limiter and state update act in the transfer cycle;
//   the command then passes the middle queue, one multiply stage, and
//   sum/round/saturate into the result queue.
//   Throughput: one command per cycle, sustained as long as pop keeps up.
//   Stall: when pop stays low the four-entry result queue fills, the back
//   end stops, the two-entry middle queue fills and full rises; nothing is
//   dropped.
//   Reset: registers return to their default values, the last applied
//   velocity is zero and both queues are empty.
module omni_base_slew_kinematics #(
    parameter int VEL_BITS = osk_pkg::VEL_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [osk_pkg::CFG_IDX_W-1:0]       cfg_addr,
    input  logic [osk_pkg::CFG_W-1:0]           cfg_wdata,
    input  logic                                push,
    output logic                                full,
    input  logic signed [osk_pkg::CMD_W-1:0]    vx_cmd,
    input  logic signed [osk_pkg::CMD_W-1:0]    vy_cmd,
    input  logic signed [osk_pkg::CMD_W-1:0]    w_cmd,
    output logic                                empty,
    input  logic                                pop,
    output logic signed [osk_pkg::TGT_W-1:0]    front_left_target,
    output logic signed [osk_pkg::TGT_W-1:0]    front_right_target,
    output logic signed [osk_pkg::TGT_W-1:0]    back_right_target,
    output logic signed [osk_pkg::TGT_W-1:0]    back_left_target
);

    localparam int MCW = $clog2(osk_pkg::MID_DEPTH + 1);

    osk_pkg::cfg_t          cfg_reg, cfg_next;
    logic                   accept;
    logic [3*VEL_BITS-1:0]  applied;
    logic [3*VEL_BITS-1:0]  mid_data;
    logic                   mid_empty;
    logic                   mid_pop;
    logic [MCW-1:0]         mid_count;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (cfg_addr)
                osk_pkg::CFG_LIMIT_ENABLE: cfg_next.limit_enable = cfg_wdata[0];
                osk_pkg::CFG_MAX_STEP_X:   cfg_next.max_step_x   = cfg_wdata;
                osk_pkg::CFG_MAX_STEP_Y:   cfg_next.max_step_y   = cfg_wdata;
                osk_pkg::CFG_MAX_STEP_W:   cfg_next.max_step_w   = cfg_wdata;
                osk_pkg::CFG_AXIS_GAIN:    cfg_next.axis_gain    = cfg_wdata;
                osk_pkg::CFG_BASE_RADIUS:  cfg_next.base_radius  = cfg_wdata;
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= osk_pkg::CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign accept = push && !full;

    osk_front #(
        .VEL_BITS (VEL_BITS)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .vx_cmd  (vx_cmd),
        .vy_cmd  (vy_cmd),
        .w_cmd   (w_cmd),
        .cfg     (cfg_reg),
        .applied (applied)
    );

    osk_fifo #(
        .WIDTH (3 * VEL_BITS),
        .DEPTH (osk_pkg::MID_DEPTH)
    ) u_mid_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (accept),
        .wr_data (applied),
        .rd_en   (mid_pop),
        .rd_data (mid_data),
        .full    (full),
        .empty   (mid_empty),
        .count   (mid_count)
    );

    osk_back #(
        .VEL_BITS  (VEL_BITS),
        .OUT_DEPTH (osk_pkg::OUT_DEPTH)
    ) u_back (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_empty           (mid_empty || (mid_count == '0)),
        .in_data            (mid_data),
        .in_pop             (mid_pop),
        .cfg                (cfg_reg),
        .pop                (pop),
        .empty              (empty),
        .front_left_target  (front_left_target),
        .front_right_target (front_right_target),
        .back_right_target  (back_right_target),
        .back_left_target   (back_left_target)
    );

endmodule
